/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lbgs_pkg.sv */
`timescale 1ns / 1ps

package lbgs_pkg;

  localparam int unsigned MAX_SAMPLES = 4096;
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);

  // Shared multiplier: signed 33x33, wide enough for 32-bit signed and unsigned operands.
  localparam int unsigned OP_W   = 33;
  localparam int unsigned PROD_W = 2 * OP_W;

  localparam int unsigned DIVD_W     = 64;
  localparam int unsigned DIVD_CNT_W = $clog2(DIVD_W);

  localparam logic [15:0] LR_RESET = 16'd655;

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] S48_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN   = 48'sh8000_0000_0000;
  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_LEARNING_RATE  = 2'd0,
    REG_INITIAL_WEIGHT = 2'd1,
    REG_INITIAL_BIAS   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                start;
    logic [DIVD_W-1:0]   dividend;
    logic [CNT_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIVD_W-1:0]   quotient;
  } div_rsp_t;

endpackage

/* design/lbgs_mul.sv */
`timescale 1ns / 1ps

module lbgs_mul (
  input  logic                                 clk_i,
  input  logic signed [lbgs_pkg::OP_W-1:0]     a_i,
  input  logic signed [lbgs_pkg::OP_W-1:0]     b_i,
  output logic signed [lbgs_pkg::PROD_W-1:0]   prod_o
);

  localparam int unsigned ProdW = lbgs_pkg::PROD_W;

  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] prod_q;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

/* design/lbgs_div.sv */
`timescale 1ns / 1ps

module lbgs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbgs_pkg::div_req_t  req_i,
  output lbgs_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned DivW  = lbgs_pkg::DIVD_W;
  localparam int unsigned CntW  = lbgs_pkg::CNT_W;
  localparam int unsigned StepW = lbgs_pkg::DIVD_CNT_W;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIX
  } div_state_e;

  div_state_e        state_q;
  logic [DivW-1:0]   quo_q;
  logic [CntW-1:0]   rem_q;
  logic [CntW-1:0]   dsr_q;
  logic              neg_q;
  logic [StepW-1:0]  step_q;
  logic [DivW-1:0]   res_q;
  logic              done_q;

  logic [DivW-1:0]   mag;
  logic [CntW:0]     rem_sh;
  logic              fits;
  logic [CntW:0]     rem_sub;
  logic [CntW-1:0]   rem_d;

  // Divide the magnitude; the divisor is always positive, so the sign follows the dividend.
  assign mag     = req_i.dividend[DivW-1] ? (~req_i.dividend + DivW'(1)) : req_i.dividend;
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign fits    = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign rem_d   = fits ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      quo_q   <= '0;
      rem_q   <= '0;
      dsr_q   <= '0;
      neg_q   <= 1'b0;
      step_q  <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (req_i.start) begin
            quo_q   <= mag;
            rem_q   <= '0;
            dsr_q   <= req_i.divisor;
            neg_q   <= req_i.dividend[DivW-1];
            step_q  <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          // One quotient bit per cycle, most significant first.
          rem_q  <= rem_d;
          quo_q  <= {quo_q[DivW-2:0], fits};
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(DivW - 1)) begin
            state_q <= D_FIX;
          end
        end
        D_FIX: begin
          res_q   <= neg_q ? (~quo_q + DivW'(1)) : quo_q;
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = res_q;

endmodule

/* design/linreg_batch_gradient_step_top.sv */
`timescale 1ns / 1ps

// One batch gradient-descent step for single-feature linear regression, Q16.16.
// Present a sample on x_sample_i/y_sample_i with start high while busy is low;
// busy then stays high while the sample goes through the shared 33x33
// multiplier (w*x), the error step, the multiplier again (error*x) and the
// accumulate step. A sample with last_sample_i set closes the batch: each of
// the two sums goes through the shift-subtract divider (a start step, 64
// quotient bits, a sign fix and the hand-back), then the learning-rate scaling
// and the update, with busy high throughout. A sample that arrives once the batch
// holds the maximum count is dropped in its accept cycle; if it closes the batch,
// busy covers only the closing steps. The new weight, bias and saturation flag
// appear for exactly one cycle, marked by result_valid_o, in the cycle busy falls;
// the receiver must take the word in that cycle, as it cannot stall the block.
// Write the configuration registers only while busy is low.
module linreg_batch_gradient_step_top (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,

  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] x_sample_i,
  input  logic signed [31:0] y_sample_i,
  input  logic               start_fresh_i,
  input  logic               last_sample_i,

  output logic               result_valid_o,
  output logic signed [31:0] new_weight_o,
  output logic signed [31:0] new_bias_o,
  output logic               saturated_o
);

  localparam int unsigned OpW   = lbgs_pkg::OP_W;
  localparam int unsigned ProdW = lbgs_pkg::PROD_W;
  localparam int unsigned CntW  = lbgs_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_WX,
    S_ERR,
    S_MUL_EX,
    S_ACC,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL_LO,
    S_MUL_HI,
    S_STEP,
    S_UPDATE
  } state_e;

  // Configuration registers
  logic [15:0]        lr_q;
  logic signed [31:0] init_w_q;
  logic signed [31:0] init_b_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q     <= lbgs_pkg::LR_RESET;
      init_w_q <= '0;
      init_b_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lbgs_pkg::REG_LEARNING_RATE:  lr_q     <= pwdata[15:0];
        lbgs_pkg::REG_INITIAL_WEIGHT: init_w_q <= pwdata;
        lbgs_pkg::REG_INITIAL_BIAS:   init_b_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lbgs_pkg::REG_LEARNING_RATE:  prdata = {16'd0, lr_q};
      lbgs_pkg::REG_INITIAL_WEIGHT: prdata = init_w_q;
      lbgs_pkg::REG_INITIAL_BIAS:   prdata = init_b_q;
      default:                      prdata = '0;
    endcase
  end

  // Sequencer and datapath state
  state_e             state_q;
  logic signed [31:0] w_q;
  logic signed [31:0] b_q;
  logic signed [63:0] wsum_q;
  logic signed [47:0] bsum_q;
  logic [CntW-1:0]    cnt_q;
  logic               sat_q;
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic               last_q;
  logic signed [31:0] err_q;
  logic signed [47:0] mean_q;
  logic [31:0]        lo_q;
  logic signed [49:0] step_q;
  logic               sel_bias_q;
  logic               valid_q;
  logic signed [31:0] out_w_q;
  logic signed [31:0] out_b_q;
  logic               out_sat_q;

  logic signed [OpW-1:0]   mul_a;
  logic signed [OpW-1:0]   mul_b;
  logic signed [ProdW-1:0] prod;

  lbgs_pkg::div_req_t div_req;
  lbgs_pkg::div_rsp_t div_rsp;

  lbgs_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  lbgs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MUL_WX: begin
        mul_a = OpW'(w_q);
        mul_b = OpW'(x_q);
      end
      S_MUL_EX: begin
        mul_a = OpW'(err_q);
        mul_b = OpW'(x_q);
      end
      // Learning rate times the mean, split into an unsigned low and a signed high part.
      S_MUL_LO: begin
        mul_a = OpW'($signed({1'b0, lr_q}));
        mul_b = OpW'($signed({1'b0, mean_q[31:0]}));
      end
      S_MUL_HI: begin
        mul_a = OpW'($signed({1'b0, lr_q}));
        mul_b = OpW'($signed(mean_q[47:32]));
      end
      default: ;
    endcase
  end

  // Error: floor(w*x / 2^16) + b - y, clamped to 32 bits
  logic signed [47:0] prod_sh;
  logic signed [49:0] diff;
  logic               err_ovf;
  logic signed [31:0] err_d;

  assign prod_sh = $signed(prod[63:16]);
  assign diff    = 50'(prod_sh) + 50'(b_q) - 50'(y_q);
  assign err_ovf = ~((&diff[49:31]) | ~(|diff[49:31]));
  assign err_d   = err_ovf ? (diff[49] ? lbgs_pkg::INT32_MIN : lbgs_pkg::INT32_MAX)
                           : $signed(diff[31:0]);

  // Accumulate with saturation at 64 and 48 bits
  logic signed [64:0] wsum_ext;
  logic               wsum_ovf;
  logic signed [63:0] wsum_d;
  logic signed [48:0] bsum_ext;
  logic               bsum_ovf;
  logic signed [47:0] bsum_d;

  assign wsum_ext = 65'(wsum_q) + 65'(prod_sh);
  assign wsum_ovf = wsum_ext[64] ^ wsum_ext[63];
  assign wsum_d   = wsum_ovf ? (wsum_ext[64] ? lbgs_pkg::INT64_MIN : lbgs_pkg::INT64_MAX)
                             : $signed(wsum_ext[63:0]);
  assign bsum_ext = 49'(bsum_q) + 49'(err_q);
  assign bsum_ovf = bsum_ext[48] ^ bsum_ext[47];
  assign bsum_d   = bsum_ovf ? (bsum_ext[48] ? lbgs_pkg::S48_MIN : lbgs_pkg::S48_MAX)
                             : $signed(bsum_ext[47:0]);

  // Mean clamp to 48 bits
  logic [63:0]        quo;
  logic               mean_ovf;
  logic signed [47:0] mean_d;

  assign quo      = div_rsp.quotient;
  assign mean_ovf = ~((&quo[63:47]) | ~(|quo[63:47]));
  assign mean_d   = mean_ovf ? (quo[63] ? lbgs_pkg::S48_MIN : lbgs_pkg::S48_MAX)
                             : $signed(quo[47:0]);

  // Step: floor((hi*2^32 + lo) / 2^16) = hi*2^16 + floor(lo / 2^16), lo being non-negative
  logic signed [32:0] hi;
  logic signed [49:0] step_d;

  assign hi     = $signed(prod[32:0]);
  assign step_d = (50'(hi) <<< 16) + 50'($signed({1'b0, lo_q}));

  // Update: old minus step, clamped to 32 bits
  logic signed [31:0] old_val;
  logic signed [50:0] upd;
  logic               upd_ovf;
  logic signed [31:0] upd_d;

  assign old_val = sel_bias_q ? b_q : w_q;
  assign upd     = 51'(old_val) - 51'(step_q);
  assign upd_ovf = ~((&upd[50:31]) | ~(|upd[50:31]));
  assign upd_d   = upd_ovf ? (upd[50] ? lbgs_pkg::INT32_MIN : lbgs_pkg::INT32_MAX)
                           : $signed(upd[31:0]);

  logic accept;
  logic room;

  assign accept = start & (state_q == S_IDLE);
  assign room   = cnt_q < CntW'(lbgs_pkg::MAX_SAMPLES);

  assign div_req.start    = (state_q == S_DIV_GO);
  assign div_req.dividend = sel_bias_q ? 64'(bsum_q) : wsum_q;
  assign div_req.divisor  = (cnt_q == '0) ? CntW'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      w_q        <= '0;
      b_q        <= '0;
      wsum_q     <= '0;
      bsum_q     <= '0;
      cnt_q      <= '0;
      sat_q      <= 1'b0;
      x_q        <= '0;
      y_q        <= '0;
      last_q     <= 1'b0;
      err_q      <= '0;
      mean_q     <= '0;
      lo_q       <= '0;
      step_q     <= '0;
      sel_bias_q <= 1'b0;
      valid_q    <= 1'b0;
      out_w_q    <= '0;
      out_b_q    <= '0;
      out_sat_q  <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            x_q        <= x_sample_i;
            y_q        <= y_sample_i;
            last_q     <= last_sample_i;
            sel_bias_q <= 1'b0;
            if (start_fresh_i) begin
              w_q    <= init_w_q;
              b_q    <= init_b_q;
              wsum_q <= '0;
              bsum_q <= '0;
              cnt_q  <= '0;
              sat_q  <= 1'b0;
            end
            if (start_fresh_i || room) begin
              state_q <= S_MUL_WX;
            end else begin
              // Batch is full: drop the word but still close on last.
              sat_q   <= 1'b1;
              state_q <= last_sample_i ? S_DIV_GO : S_IDLE;
            end
          end
        end
        S_MUL_WX: state_q <= S_ERR;
        S_ERR: begin
          err_q   <= err_d;
          sat_q   <= sat_q | err_ovf;
          state_q <= S_MUL_EX;
        end
        S_MUL_EX: state_q <= S_ACC;
        S_ACC: begin
          wsum_q  <= wsum_d;
          bsum_q  <= bsum_d;
          cnt_q   <= cnt_q + CntW'(1);
          sat_q   <= sat_q | wsum_ovf | bsum_ovf;
          state_q <= last_q ? S_DIV_GO : S_IDLE;
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            mean_q  <= mean_d;
            sat_q   <= sat_q | mean_ovf;
            state_q <= S_MUL_LO;
          end
        end
        S_MUL_LO: state_q <= S_MUL_HI;
        S_MUL_HI: begin
          lo_q    <= prod[47:16];
          state_q <= S_STEP;
        end
        S_STEP: begin
          step_q  <= step_d;
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          if (!sel_bias_q) begin
            w_q        <= upd_d;
            sat_q      <= sat_q | upd_ovf;
            sel_bias_q <= 1'b1;
            state_q    <= S_DIV_GO;
          end else begin
            b_q       <= upd_d;
            out_w_q   <= w_q;
            out_b_q   <= upd_d;
            out_sat_q <= sat_q | upd_ovf;
            valid_q   <= 1'b1;
            wsum_q    <= '0;
            bsum_q    <= '0;
            cnt_q     <= '0;
            sat_q     <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign new_weight_o   = out_w_q;
  assign new_bias_o     = out_b_q;
  assign saturated_o    = out_sat_q;

endmodule

/* design/lbgs_checker.sv */
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lbgs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o
);

  // A result word is a single-cycle strobe.
  `CHK_NEXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe held too long")

  // Only an accepted sample takes the block out of idle.
  `CHK_NEXT(a_idle_holds, !start && !busy, !busy, "block left idle without an accept")

  // Results leave only once the block is free again.
  `CHK_IMPLY(a_strobe_idle, result_valid_o, !busy, "result strobe while busy")

  // No result can follow an accept in the very next cycle.
  `CHK_NEXT(a_no_instant_result, start && !busy, !result_valid_o, "result right after accept")

endmodule

bind linreg_batch_gradient_step_top lbgs_checker u_lbgs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o)
);

/* bench/tb_linreg_batch_gradient_step_top.sv */
`timescale 1ns / 1ps

module tb_linreg_batch_gradient_step_top;

  localparam int SETTLE_CYCLES  = 300;
  localparam int RANDOM_PER_PHS = 200;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               fresh;
    logic               last;
  } sample_t;

  typedef struct {
    logic signed [31:0] weight;
    logic signed [31:0] bias;
    logic               sat;
  } update_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic               start         = 1'b0;
  logic               busy;
  logic signed [31:0] x_sample      = '0;
  logic signed [31:0] y_sample      = '0;
  logic               start_fresh   = 1'b0;
  logic               last_sample   = 1'b0;
  logic               result_valid_o;
  logic signed [31:0] new_weight_o;
  logic signed [31:0] new_bias_o;
  logic               saturated_o;

  sample_t samples_pending[$];
  update_t updates_predicted[$];
  int      idle_pct       = 9;
  int      mismatch_count = 0;
  logic    took_q         = 1'b0;

  // configuration copy and fit state of the predictor
  logic [15:0]        cfg_lr     = lbgs_pkg::LR_RESET;
  logic signed [31:0] cfg_weight = '0;
  logic signed [31:0] cfg_bias   = '0;
  logic signed [31:0] fit_weight = '0;
  logic signed [31:0] fit_bias   = '0;
  longint             err_x_sum  = 0;
  longint             err_sum    = 0;
  int unsigned        n_samples  = 0;
  bit                 sat_seen   = 1'b0;

  linreg_batch_gradient_step_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .x_sample_i     (x_sample),
    .y_sample_i     (y_sample),
    .start_fresh_i  (start_fresh),
    .last_sample_i  (last_sample),
    .result_valid_o (result_valid_o),
    .new_weight_o   (new_weight_o),
    .new_bias_o     (new_bias_o),
    .saturated_o    (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp_track(longint v, longint lo, longint hi);
    if (v > hi) begin
      sat_seen = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat_seen = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint sat_add_track(longint a, longint b);
    if (b > 0 && a > lbgs_pkg::INT64_MAX - b) begin
      sat_seen = 1'b1;
      return lbgs_pkg::INT64_MAX;
    end
    if (b < 0 && a < lbgs_pkg::INT64_MIN - b) begin
      sat_seen = 1'b1;
      return lbgs_pkg::INT64_MIN;
    end
    return a + b;
  endfunction

  function automatic logic signed [31:0] descend(logic signed [31:0] old, longint sum,
                                                 longint cnt);
    longint mean;
    longint delta;
    mean  = clamp_track(sum / cnt, lbgs_pkg::S48_MIN, lbgs_pkg::S48_MAX);
    delta = (longint'(cfg_lr) * mean) >>> 16;
    return 32'(clamp_track(longint'(old) - delta, lbgs_pkg::INT32_MIN,
                           lbgs_pkg::INT32_MAX));
  endfunction

  function automatic void clear_batch();
    err_x_sum = 0;
    err_sum   = 0;
    n_samples = 0;
    sat_seen  = 1'b0;
  endfunction

  function automatic void absorb_sample(sample_t s);
    longint pred;
    longint err;
    longint grad;
    longint cnt;
    if (s.fresh) begin
      fit_weight = cfg_weight;
      fit_bias   = cfg_bias;
      clear_batch();
    end
    if (n_samples < lbgs_pkg::MAX_SAMPLES) begin
      pred      = ((longint'(fit_weight) * longint'(s.x)) >>> 16) + longint'(fit_bias);
      err       = clamp_track(pred - longint'(s.y), lbgs_pkg::INT32_MIN,
                              lbgs_pkg::INT32_MAX);
      grad      = (err * longint'(s.x)) >>> 16;
      err_x_sum = sat_add_track(err_x_sum, grad);
      err_sum   = clamp_track(err_sum + err, lbgs_pkg::S48_MIN, lbgs_pkg::S48_MAX);
      n_samples++;
    end else begin
      // batch full: drop the sample
      sat_seen = 1'b1;
    end
    if (s.last) begin
      cnt        = (n_samples != 0) ? longint'(n_samples) : 1;
      fit_weight = descend(fit_weight, err_x_sum, cnt);
      fit_bias   = descend(fit_bias, err_sum, cnt);
      updates_predicted.push_back('{fit_weight, fit_bias, sat_seen});
      clear_batch();
    end
  endfunction

  function automatic logic signed [31:0] q16_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return lbgs_pkg::INT32_MIN;
          1:       return lbgs_pkg::INT32_MAX;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sh0001_0000;
        endcase
      end
      1, 2, 3, 4, 5: return 32'($urandom_range(32'h0010_0000)) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic int push_random_batch();
    int len;
    bit fresh_first;
    bit closed;
    len         = ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    fresh_first = $urandom_range(3) != 0;
    closed      = $urandom_range(9) != 0;
    for (int i = 0; i < len; i++) begin
      samples_pending.push_back('{q16_value(), q16_value(),
                                 (i == 0 && fresh_first) || $urandom_range(49) == 0,
                                 (i == len - 1 && closed) || $urandom_range(49) == 0});
    end
    return len;
  endfunction

  task automatic cfg_write(lbgs_pkg::cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lbgs_pkg::REG_LEARNING_RATE:  cfg_lr     = val[15:0];
      lbgs_pkg::REG_INITIAL_WEIGHT: cfg_weight = val;
      lbgs_pkg::REG_INITIAL_BIAS:   cfg_bias   = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (samples_pending.size() == 0 && !start);
    wait (updates_predicted.size() == 0);
    // non-closing samples leave no trace, so let the block finish them
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver: hold the word until taken, then advance
  always @(negedge clk_i) begin
    if (start && took_q) void'(samples_pending.pop_front());
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took_q) begin
      // hold
    end else if (samples_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
      start       <= 1'b1;
      x_sample    <= samples_pending[0].x;
      y_sample    <= samples_pending[0].y;
      start_fresh <= samples_pending[0].fresh;
      last_sample <= samples_pending[0].last;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check result words, feed accepted samples to the predictor
  always @(posedge clk_i) begin : monitor
    update_t want;
    if (rst_ni && result_valid_o) begin
      if (updates_predicted.size() == 0) begin
        $error("result word with no update predicted");
        mismatch_count++;
      end else begin
        want = updates_predicted.pop_front();
        if (new_weight_o !== want.weight) begin
          $error("new_weight: expected %0d, got %0d", want.weight, new_weight_o);
          mismatch_count++;
        end
        if (new_bias_o !== want.bias) begin
          $error("new_bias: expected %0d, got %0d", want.bias, new_bias_o);
          mismatch_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, saturated_o);
          mismatch_count++;
        end
      end
    end
    if (rst_ni && start && !busy)
      absorb_sample('{x_sample, y_sample, start_fresh, last_sample});
    took_q <= rst_ni && start && !busy;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [15:0]        lr;
    logic signed [31:0] w0;
    logic signed [31:0] b0;
    int                 n;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single-sample batch, then a batch across the extremes
    samples_pending.push_back('{32'sh0001_0000, 32'sh0002_0000, 1'b1, 1'b1});
    samples_pending.push_back('{lbgs_pkg::INT32_MIN, lbgs_pkg::INT32_MAX, 1'b1, 1'b0});
    samples_pending.push_back('{lbgs_pkg::INT32_MAX, lbgs_pkg::INT32_MIN, 1'b0, 1'b0});
    samples_pending.push_back('{32'sd0, -32'sd1, 1'b0, 1'b1});
    // continue from the kept weight and bias
    samples_pending.push_back('{-32'sd1, 32'sd0, 1'b0, 1'b1});
    samples_pending.push_back('{32'sh0003_0000, -32'sh0001_8000, 1'b0, 1'b0});
    samples_pending.push_back('{-32'sh0002_0000, 32'sh0004_0000, 1'b0, 1'b1});
    // restart in the middle of a batch
    samples_pending.push_back('{32'sh0002_0000, 32'sh0001_0000, 1'b1, 1'b0});
    samples_pending.push_back('{32'sh0000_8000, -32'sh0000_8000, 1'b1, 1'b1});
    samples_pending.push_back('{lbgs_pkg::INT32_MAX, lbgs_pkg::INT32_MAX, 1'b1, 1'b1});
    samples_pending.push_back('{lbgs_pkg::INT32_MIN, lbgs_pkg::INT32_MIN, 1'b1, 1'b1});
    samples_pending.push_back('{32'sd0, 32'sd0, 1'b1, 1'b1});
    samples_pending.push_back('{32'sh0001_0000, 32'sh0003_0000, 1'b1, 1'b0});
    samples_pending.push_back('{32'sh0002_0000, 32'sh0005_0000, 1'b0, 1'b0});
    samples_pending.push_back('{32'sh0003_0000, 32'sh0007_0000, 1'b0, 1'b0});
    samples_pending.push_back('{32'sh0004_0000, 32'sh0009_0000, 1'b0, 1'b1});

    for (int ph = 1; ph <= 6; ph++) begin
      drain();
      case (ph)
        1: begin
          lr = 16'd0;
          w0 = lbgs_pkg::INT32_MAX;
          b0 = lbgs_pkg::INT32_MIN;
        end
        2: begin
          lr = 16'hFFFF;
          w0 = lbgs_pkg::INT32_MIN;
          b0 = lbgs_pkg::INT32_MAX;
        end
        3: begin
          lr = 16'($urandom());
          w0 = q16_value();
          b0 = q16_value();
        end
        4: begin
          lr = 16'd1;
          w0 = 32'sd0;
          b0 = 32'sd0;
        end
        5: begin
          lr = 16'hFFFF;
          w0 = $urandom();
          b0 = $urandom();
        end
        default: begin
          lr = lbgs_pkg::LR_RESET;
          w0 = 32'sh0001_0000;
          b0 = -32'sh0000_8000;
        end
      endcase
      cfg_write(lbgs_pkg::REG_LEARNING_RATE, {16'd0, lr});
      cfg_write(lbgs_pkg::REG_INITIAL_WEIGHT, w0);
      cfg_write(lbgs_pkg::REG_INITIAL_BIAS, b0);
      idle_pct = (ph <= 2) ? 9 : (ph <= 4) ? 85 : 0;
      n = 0;
      while (n < RANDOM_PER_PHS) n += push_random_batch();
    end
    drain();

    if (mismatch_count == 0 && updates_predicted.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* linreg_batch_gradient_step_top.f */
+incdir+design
design/lbgs_pkg.sv
design/lbgs_mul.sv
design/lbgs_div.sv
design/linreg_batch_gradient_step_top.sv
design/lbgs_checker.sv
bench/tb_linreg_batch_gradient_step_top.sv
